@@ src/dtp_pkg.sv @@
// ----------------------------------------------------------------------------
// dtp_pkg: shared types and constants for disparity_to_point
// Register map, fixed field widths and the divider split.
// ----------------------------------------------------------------------------
`default_nettype none

package dtp_pkg;

    // register index of the configuration port
    typedef logic [2:0] t_cfg_idx;

    localparam t_cfg_idx CFG_BASELINE_FOCAL = 3'd0;
    localparam t_cfg_idx CFG_CENTER_X       = 3'd1;
    localparam t_cfg_idx CFG_CENTER_Y       = 3'd2;
    localparam t_cfg_idx CFG_INV_FOCAL_X    = 3'd3;
    localparam t_cfg_idx CFG_INV_FOCAL_Y    = 3'd4;

    // fixed widths
    localparam int CFG_DATA_W = 32;   // widest register
    localparam int BF_W       = 32;   // baseline * focal, Q16.16
    localparam int CEN_W      = 28;   // principal point, Q12.16
    localparam int INV_W      = 32;   // 1/f, Q0.32
    localparam int FRAC_W     = 16;   // fraction bits of Q16.16
    localparam int PT_W       = 32;   // lateral / vertical result
    localparam int Z_W        = 31;   // depth result

    typedef logic [PT_W-1:0] t_point;
    typedef logic [Z_W-1:0]  t_depth;

    // register reset values
    localparam logic [BF_W-1:0]  RST_BASELINE_FOCAL = 32'd3139593;
    localparam logic [CEN_W-1:0] RST_CENTER_X       = 28'd24081315;
    localparam logic [CEN_W-1:0] RST_CENTER_Y       = 28'd16528237;
    localparam logic [INV_W-1:0] RST_INV_FOCAL     = 32'd9868844;

    // divider: one quotient bit per step, several steps per stage
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = BF_W / DIV_STEP;

    // saturation limits
    localparam t_depth Z_MAX  = {Z_W{1'b1}};
    localparam t_point PT_MAX = {1'b0, {(PT_W-1){1'b1}}};
    localparam t_point PT_MIN = {1'b1, {(PT_W-1){1'b0}}};

endpackage

`default_nettype wire

@@ src/disparity_to_point.sv @@
// ----------------------------------------------------------------------------
// disparity_to_point: stereo disparity to 3D point reprojection
// Pinhole model in fixed point: z = bf / d, x = (u - cx) * z / fx,
// y = (v - cy) * z / fy, all saturated.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (i_in_valid / o_in_ready) carries one pixel per
//   transaction: disparity, column and row. A zero disparity is accepted
//   and gives no output transaction.
//   Output channel (o_out_valid / i_out_ready) carries one point per
//   transaction with a nonzero disparity, in input order.
//   Throughput: one pixel per clock cycle while the skid buffer is empty.
//   Pipeline: the depth divider makes up most of it, with 8 stages of 4
//   restoring quotient bits each, then offset, three multiplier stages,
//   sum and saturation, ahead of the output register.
//   Configuration is written through i_cfg_wr_en / i_cfg_index / i_cfg_data;
//   indexes above 4 are ignored. Keeping no pixel in flight is up to the user.
//   Reset (synchronous, active low) empties the pipeline and loads the
//   default camera calibration.
//   Receiver stall: the output register holds its point and a one-entry
//   skid buffer catches the next one; only when the skid buffer is full
//   does the pipeline freeze and o_in_ready drop.
// ----------------------------------------------------------------------------
`default_nettype none

module disparity_to_point
    import dtp_pkg::*;
#(
    parameter int DISP_BITS  = 8,
    parameter int COORD_BITS = 12
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // configuration write port
    input  wire logic                   i_cfg_wr_en,
    input  wire t_cfg_idx               i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    // pixel input
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic [DISP_BITS-1:0]   i_disparity,
    input  wire logic [COORD_BITS-1:0]  i_column,
    input  wire logic [COORD_BITS-1:0]  i_row,
    // point output
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic signed [PT_W-1:0]      o_point_x,
    output logic signed [PT_W-1:0]      o_point_y,
    output logic [Z_W-1:0]              o_point_z
);

    // derived widths
    localparam int DW    = DISP_BITS + BF_W;               // remainder + quotient
    localparam int POS_W = COORD_BITS + FRAC_W;
    localparam int MAG_W = (POS_W > CEN_W) ? POS_W : CEN_W;
    localparam int M1_W  = MAG_W + Z_W;                     // |du| * z
    localparam int HI_W  = M1_W - INV_W;                    // upper part of m1
    localparam int A_W   = HI_W + INV_W;                    // hi * inv_f
    localparam int B_W   = 2 * INV_W;                       // lo * inv_f
    localparam int SUM_W = A_W + 1;
    localparam int Q_W   = SUM_W - FRAC_W;                  // magnitude, Q28.16

    // configuration registers
    logic [BF_W-1:0]  r_baseline_focal;
    logic [CEN_W-1:0] r_center [2];
    logic [INV_W-1:0] r_inv_focal [2];

    // pipeline control
    logic w_adv;

    // divider stages
    logic                  r_div_valid [DIV_STAGES+1];
    logic [DW-1:0]         r_div_w     [DIV_STAGES+1];
    logic [DISP_BITS-1:0]  r_div_disp  [DIV_STAGES];
    logic [COORD_BITS-1:0] r_div_col   [DIV_STAGES+1];
    logic [COORD_BITS-1:0] r_div_row   [DIV_STAGES+1];
    logic [DW-1:0]         c_div_w     [1:DIV_STAGES];
    logic [DW-1:0]         c_acc;
    logic [DW:0]           c_shift;
    logic [DISP_BITS:0]    c_upper;
    logic [DISP_BITS:0]    c_diff;

    // offset stage
    logic [BF_W-1:0]       c_quot;
    t_depth                c_depth;
    logic [COORD_BITS-1:0] c_pix [2];
    logic [MAG_W-1:0]      c_pos [2];
    logic [MAG_W-1:0]      c_cen [2];
    logic                  c_neg [2];
    logic [MAG_W-1:0]      c_mag [2];
    logic                  r_z_valid;
    t_depth                r_z_depth;
    logic [MAG_W-1:0]      r_z_mag [2];
    logic                  r_z_neg [2];

    // multiplier stages
    logic                  r_m1_valid;
    t_depth                r_m1_depth;
    logic [M1_W-1:0]       r_m1_prod [2];
    logic                  r_m1_neg  [2];
    logic                  r_m2_valid;
    t_depth                r_m2_depth;
    logic [A_W-1:0]        r_m2_a    [2];
    logic [INV_W-1:0]      r_m2_lo   [2];
    logic                  r_m2_neg  [2];
    logic                  r_m3_valid;
    t_depth                r_m3_depth;
    logic [A_W-1:0]        r_m3_a    [2];
    logic [B_W-1:0]        r_m3_b    [2];
    logic                  r_m3_neg  [2];

    // sum and saturation stages
    logic [SUM_W-1:0]      c_sum [2];
    logic                  r_s_valid;
    t_depth                r_s_depth;
    logic [Q_W-1:0]        r_s_mag [2];
    logic                  r_s_neg [2];
    logic                  c_big   [2];
    t_point                c_pt    [2];
    logic                  r_t_valid;
    t_depth                r_t_depth;
    t_point                r_t_pt [2];

    // output register and skid buffer
    logic                  r_out_valid;
    t_point                r_out_x;
    t_point                r_out_y;
    t_depth                r_out_z;
    logic                  r_skid_valid;
    t_point                r_skid_x;
    t_point                r_skid_y;
    t_depth                r_skid_z;

    // configuration write decoder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_baseline_focal <= RST_BASELINE_FOCAL;
            r_center[0]      <= RST_CENTER_X;
            r_center[1]      <= RST_CENTER_Y;
            r_inv_focal[0]   <= RST_INV_FOCAL;
            r_inv_focal[1]   <= RST_INV_FOCAL;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_BASELINE_FOCAL: r_baseline_focal <= i_cfg_data[BF_W-1:0];
                CFG_CENTER_X:       r_center[0]      <= i_cfg_data[CEN_W-1:0];
                CFG_CENTER_Y:       r_center[1]      <= i_cfg_data[CEN_W-1:0];
                CFG_INV_FOCAL_X:    r_inv_focal[0]   <= i_cfg_data[INV_W-1:0];
                CFG_INV_FOCAL_Y:    r_inv_focal[1]   <= i_cfg_data[INV_W-1:0];
                default: ;
            endcase
        end
    end

    // whole pipeline moves unless the skid buffer is holding a point
    assign w_adv      = !r_skid_valid;
    assign o_in_ready = w_adv;

    // restoring division steps, DIV_STEP quotient bits per stage
    always_comb begin
        c_acc   = '0;
        c_shift = '0;
        c_upper = '0;
        c_diff  = '0;
        for (int s = 1; s <= DIV_STAGES; s++) begin
            c_acc = r_div_w[s-1];
            for (int k = 0; k < DIV_STEP; k++) begin
                c_shift = {c_acc, 1'b0};
                c_upper = c_shift[DW:BF_W];
                if (c_upper >= {1'b0, r_div_disp[s-1]}) begin
                    c_diff = c_upper - {1'b0, r_div_disp[s-1]};
                    c_acc  = {c_diff[DISP_BITS-1:0], c_shift[BF_W-1:1], 1'b1};
                end else begin
                    c_acc  = c_shift[DW-1:0];
                end
            end
            c_div_w[s] = c_acc;
        end
    end

    // depth saturation and signed offsets from the principal point
    always_comb begin
        c_quot   = r_div_w[DIV_STAGES][BF_W-1:0];
        c_depth  = c_quot[BF_W-1] ? Z_MAX : c_quot[Z_W-1:0];
        c_pix[0] = r_div_col[DIV_STAGES];
        c_pix[1] = r_div_row[DIV_STAGES];
        for (int l = 0; l < 2; l++) begin
            c_pos[l] = MAG_W'({c_pix[l], {FRAC_W{1'b0}}});
            c_cen[l] = MAG_W'(r_center[l]);
            c_neg[l] = c_pos[l] < c_cen[l];
            c_mag[l] = c_neg[l] ? (c_cen[l] - c_pos[l]) : (c_pos[l] - c_cen[l]);
        end
    end

    // magnitude sum, truncation and signed saturation
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            c_sum[l] = SUM_W'(r_m3_a[l]) + SUM_W'(r_m3_b[l][B_W-1:INV_W]);
            c_big[l] = |r_s_mag[l][Q_W-1:PT_W-1];
            if (r_s_neg[l]) begin
                c_pt[l] = c_big[l] ? PT_MIN : t_point'(~r_s_mag[l][PT_W-1:0] + 1'b1);
            end else begin
                c_pt[l] = c_big[l] ? PT_MAX : r_s_mag[l][PT_W-1:0];
            end
        end
    end

    // pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= DIV_STAGES; s++) begin
                r_div_valid[s] <= 1'b0;
            end
            r_z_valid  <= 1'b0;
            r_m1_valid <= 1'b0;
            r_m2_valid <= 1'b0;
            r_m3_valid <= 1'b0;
            r_s_valid  <= 1'b0;
            r_t_valid  <= 1'b0;
        end else if (w_adv) begin
            // zero disparity is taken in but carries no valid bit
            r_div_valid[0] <= i_in_valid && (i_disparity != '0);
            for (int s = 1; s <= DIV_STAGES; s++) begin
                r_div_valid[s] <= r_div_valid[s-1];
            end
            r_z_valid  <= r_div_valid[DIV_STAGES];
            r_m1_valid <= r_z_valid;
            r_m2_valid <= r_m1_valid;
            r_m3_valid <= r_m2_valid;
            r_s_valid  <= r_m3_valid;
            r_t_valid  <= r_s_valid;
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // stage 0: load dividend, remainder cleared
            r_div_w[0]    <= {{DISP_BITS{1'b0}}, r_baseline_focal};
            r_div_disp[0] <= i_disparity;
            r_div_col[0]  <= i_column;
            r_div_row[0]  <= i_row;
            for (int s = 1; s <= DIV_STAGES; s++) begin
                r_div_w[s]   <= c_div_w[s];
                r_div_col[s] <= r_div_col[s-1];
                r_div_row[s] <= r_div_row[s-1];
            end
            for (int s = 1; s < DIV_STAGES; s++) begin
                r_div_disp[s] <= r_div_disp[s-1];
            end
            // depth and offsets
            r_z_depth  <= c_depth;
            r_m1_depth <= r_z_depth;
            r_m2_depth <= r_m1_depth;
            r_m3_depth <= r_m2_depth;
            r_s_depth  <= r_m3_depth;
            r_t_depth  <= r_s_depth;
            for (int l = 0; l < 2; l++) begin
                r_z_mag[l]   <= c_mag[l];
                r_z_neg[l]   <= c_neg[l];
                // |du| * z
                r_m1_prod[l] <= M1_W'(r_z_mag[l]) * M1_W'(r_z_depth);
                r_m1_neg[l]  <= r_z_neg[l];
                // upper half times 1/f
                r_m2_a[l]    <= A_W'(r_m1_prod[l][M1_W-1:INV_W]) * A_W'(r_inv_focal[l]);
                r_m2_lo[l]   <= r_m1_prod[l][INV_W-1:0];
                r_m2_neg[l]  <= r_m1_neg[l];
                // lower half times 1/f
                r_m3_a[l]    <= r_m2_a[l];
                r_m3_b[l]    <= B_W'(r_m2_lo[l]) * B_W'(r_inv_focal[l]);
                r_m3_neg[l]  <= r_m2_neg[l];
                // drop 48 fraction bits in total
                r_s_mag[l]   <= c_sum[l][SUM_W-1:FRAC_W];
                r_s_neg[l]   <= r_m3_neg[l];
                r_t_pt[l]    <= c_pt[l];
            end
        end
    end

    // output register and skid buffer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_out_ready || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= r_t_valid;
            end
        end else if (r_t_valid && !r_skid_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    // output register and skid buffer data
    always_ff @(posedge i_clk) begin
        if (i_out_ready || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_x <= r_skid_x;
                r_out_y <= r_skid_y;
                r_out_z <= r_skid_z;
            end else begin
                r_out_x <= r_t_pt[0];
                r_out_y <= r_t_pt[1];
                r_out_z <= r_t_depth;
            end
        end else if (!r_skid_valid) begin
            r_skid_x <= r_t_pt[0];
            r_skid_y <= r_t_pt[1];
            r_skid_z <= r_t_depth;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_point_x   = $signed(r_out_x);
    assign o_point_y   = $signed(r_out_y);
    assign o_point_z   = r_out_z;

    // skid buffer only fills behind a held output transaction
    a_skid_behind_out: assert property (@(posedge i_clk)
        r_skid_valid |-> r_out_valid)
        else $error("skid buffer holds a point while output register is empty");

    // a point leaving the pipeline during a stall is caught by the skid buffer
    a_stall_catch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready && r_t_valid && w_adv) |=> r_skid_valid)
        else $error("point lost while receiver stalled");

    // reset empties the output side
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_out_valid && !r_skid_valid))
        else $error("output not empty after reset");

endmodule

`default_nettype wire
